### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the latency histogram.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/elh_pkg.sv
// ----------------------------------------------------------------------------
// elh_pkg
// Types and constants of the estimated latency histogram.
// ----------------------------------------------------------------------------
package elh_pkg;

    localparam int CNT_W   = 32;
    localparam int BOUND_W = 40;
    localparam int OUT_W   = 32;
    localparam int SAMP_W  = 32;
    localparam int ACC_W   = 64;
    localparam int DIVC_W  = 6;

    // Percentile ratios, numerator over denominator.
    localparam int P95_NUM  = 95;
    localparam int P95_DEN  = 100;
    localparam int P99_NUM  = 99;
    localparam int P99_DEN  = 100;
    localparam int P999_NUM = 999;
    localparam int P999_DEN = 1000;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_CLEAR   = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_END,
        ST_WALK_RD,
        ST_WALK_MUL,
        ST_WALK_PROD,
        ST_WALK_SUM,
        ST_DONE
    } state_t;

endpackage

### rtl/core/estimated_latency_histogram.sv
// ----------------------------------------------------------------------------
// estimated_latency_histogram
// Geometric-bucket latency histogram with percentile, mean and max readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready; s_tuser carries the opcode (add,
//   compute, clear) and s_tdata the sample. Only compute produces an output
//   item on m_tvalid/m_tready, carrying mean, p95, p99, p999 and max.
//   The block works on one item at a time; s_tready is high when it is idle.
//   An add keeps the block busy for a binary search over the bound table,
//   then one read-modify-write of the count memory, whose registered read
//   sets the last two steps. A clear or an unused opcode does not take the
//   block out of idle. A compute makes two passes over the count memory,
//   a sum of the counts and a walk for percentiles and the weighted sum,
//   then one run of a bit-serial 64-bit divider for the mean; the divider
//   is skipped on an empty histogram.
//   At reset all per-bucket valid bits drop, so every count reads as zero at
//   once; no clearing pass is needed. A clear does the same.
//   The compute result sits in an output register; while the receiver stalls,
//   adds and clears are still taken, and a further compute waits at its end
//   until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module estimated_latency_histogram #(
    parameter int NUM_BUCKETS = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] sample_value
    input  logic [1:0]   s_tuser,   // [1:0] opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // mean, p95, p99, p999, max, 32 bits each
);

    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam int SUM_W = elh_pkg::CNT_W + IDX_W;
    localparam int SC_W  = SUM_W + 10;
    localparam int ACC_W = elh_pkg::ACC_W;
    localparam int BW    = elh_pkg::BOUND_W;
    localparam int CW    = elh_pkg::CNT_W;
    localparam int OW    = elh_pkg::OUT_W;
    localparam int HALF  = BW / 2;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUCKETS - 2);

    typedef logic [NUM_BUCKETS-1:0][BW-1:0] bound_arr_t;

    // Geometric bound table, built at elaboration.
    function automatic bound_arr_t build_bounds();
        bound_arr_t arr;
        logic [BW+3:0] prev;
        logic [BW+3:0] nxt;
        arr  = '0;
        prev = (BW+4)'(1);
        arr[0] = BW'(prev);
        for (int k = 1; k < NUM_BUCKETS; k++)
        begin
            nxt = (prev * 6) / 5;
            if (nxt <= prev)
                nxt = prev + 1'b1;
            if (nxt > {4'd0, {BW{1'b1}}})
                nxt = {4'd0, {BW{1'b1}}};
            arr[k] = BW'(nxt);
            prev   = nxt;
        end
        return arr;
    endfunction

    localparam bound_arr_t BOUNDS = build_bounds();

    elh_pkg::state_t   state_reg, state_next;

    logic [NUM_BUCKETS-1:0] valid_reg;
    logic [IDX_W-1:0]       idx_reg, lo_reg, hi_reg;
    logic [31:0]            sample_reg;
    logic [CW-1:0]          max_reg, mean_reg;
    logic [SUM_W-1:0]       total_reg, run_reg;
    logic [SC_W-1:0]        t95_reg, t99_reg, t999_reg;
    logic [ACC_W-1:0]       wsum_reg, prod_reg;
    logic [BW-1:0]          v95_reg, v99_reg, v999_reg, bound_reg;
    logic                   h95_reg, h99_reg, h999_reg;
    logic [CW+HALF-1:0]     plo_reg, phi_reg;
    logic [ACC_W-1:0]       num_reg, den_reg, rem_reg;
    logic [elh_pkg::DIVC_W-1:0] dcnt_reg;
    logic                   m_valid_reg;
    logic [159:0]           m_data_reg;

    // Count memory, synchronous read into a register.
    logic [CW-1:0] cnt_mem [NUM_BUCKETS];
    logic [CW-1:0] rd_data_reg;
    logic          ram_we;
    logic [CW-1:0] ram_wdata;

    always_ff @(posedge clk)
    begin
        if (ram_we)
            cnt_mem[idx_reg] <= ram_wdata;
        rd_data_reg <= cnt_mem[idx_reg];
    end

    // Combinational helpers.
    logic [IDX_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid;
    logic [CW-1:0]      cnt_val;
    logic [SUM_W-1:0]   run_new;
    logic [SUM_W:0]     run_p1;
    logic               hit95, hit99, hit999;
    logic [BW+CW-1:0]   prod_full;
    logic [ACC_W:0]     wsum_add;
    logic [ACC_W:0]     rem_shift;
    logic               div_bit;
    logic               accept, out_free;
    logic [OW:0]        mean_inc;

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} + 1'b1;
    assign mid       = mid_sum[IDX_W:1];
    assign cnt_val   = valid_reg[idx_reg] ? rd_data_reg : '0;
    assign run_new   = run_reg + SUM_W'(cnt_val);
    assign prod_full = {phi_reg, {HALF{1'b0}}} + (BW+CW)'(plo_reg);
    assign wsum_add  = {1'b0, wsum_reg} + {1'b0, prod_reg};
    assign rem_shift = {rem_reg, num_reg[ACC_W-1]};
    assign div_bit   = (rem_shift >= {1'b0, den_reg});
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign mean_inc  = {1'b0, num_reg[OW-1:0]} + (OW+1)'(rem_reg != '0);

    // Percentile test: run >= floor(total*num/den) holds exactly when
    // total*num < den*(run+1), so no division is needed.
    assign run_p1 = {1'b0, run_reg} + 1'b1;
    assign hit95  = t95_reg < SC_W'(run_p1) * SC_W'(elh_pkg::P95_DEN);
    assign hit99  = t99_reg < SC_W'(run_p1) * SC_W'(elh_pkg::P99_DEN);
    assign hit999 = t999_reg < SC_W'(run_p1) * SC_W'(elh_pkg::P999_DEN);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            elh_pkg::ST_IDLE:
            begin
                if (accept && s_tuser == elh_pkg::OP_ADD)
                    state_next = elh_pkg::ST_SEARCH;
                else if (accept && s_tuser == elh_pkg::OP_COMPUTE)
                    state_next = elh_pkg::ST_SUM_RD;
            end
            elh_pkg::ST_SEARCH:
                if (lo_reg == hi_reg)
                    state_next = elh_pkg::ST_ADD_RD;
            elh_pkg::ST_ADD_RD:   state_next = elh_pkg::ST_ADD_WR;
            elh_pkg::ST_ADD_WR:   state_next = elh_pkg::ST_IDLE;
            elh_pkg::ST_SUM_RD:   state_next = elh_pkg::ST_SUM_ACC;
            elh_pkg::ST_SUM_ACC:
                state_next = (idx_reg == LAST_IDX) ? elh_pkg::ST_WALK_RD
                                                   : elh_pkg::ST_SUM_RD;
            elh_pkg::ST_DIV_LOAD: state_next = elh_pkg::ST_DIV_RUN;
            elh_pkg::ST_DIV_RUN:
                if (dcnt_reg == '1)
                    state_next = elh_pkg::ST_DIV_END;
            elh_pkg::ST_DIV_END:  state_next = elh_pkg::ST_DONE;
            elh_pkg::ST_WALK_RD:   state_next = elh_pkg::ST_WALK_MUL;
            elh_pkg::ST_WALK_MUL:  state_next = elh_pkg::ST_WALK_PROD;
            elh_pkg::ST_WALK_PROD: state_next = elh_pkg::ST_WALK_SUM;
            elh_pkg::ST_WALK_SUM:
            begin
                if (idx_reg != LAST_IDX)
                    state_next = elh_pkg::ST_WALK_RD;
                else if (run_reg != '0)
                    state_next = elh_pkg::ST_DIV_LOAD;
                else
                    state_next = elh_pkg::ST_DONE;
            end
            elh_pkg::ST_DONE:
                if (out_free)
                    state_next = elh_pkg::ST_IDLE;
            default: state_next = elh_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        s_tready  = (state_reg == elh_pkg::ST_IDLE);
        ram_we    = (state_reg == elh_pkg::ST_ADD_WR);
        ram_wdata = (cnt_val == '1) ? cnt_val : cnt_val + 1'b1;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= elh_pkg::ST_IDLE;
            valid_reg   <= '0;
            max_reg     <= '0;
            mean_reg    <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            dcnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // The output register fills at the end of a compute and empties
            // when the receiver takes the item.
            if (state_reg == elh_pkg::ST_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                elh_pkg::ST_IDLE:
                begin
                    idx_reg    <= '0;
                    lo_reg     <= '0;
                    hi_reg     <= LAST_IDX;
                    sample_reg <= s_tdata;
                    total_reg  <= '0;
                    if (accept && s_tuser == elh_pkg::OP_CLEAR)
                    begin
                        valid_reg <= '0;
                        max_reg   <= '0;
                        mean_reg  <= '0;
                    end
                end
                elh_pkg::ST_SEARCH:
                begin
                    if (lo_reg == hi_reg)
                        idx_reg <= lo_reg;
                    else if (BOUNDS[mid] <= BW'(sample_reg))
                        lo_reg <= mid;
                    else
                        hi_reg <= mid - 1'b1;
                end
                elh_pkg::ST_ADD_RD:
                begin
                end
                elh_pkg::ST_ADD_WR:
                begin
                    valid_reg[idx_reg] <= 1'b1;
                    if (sample_reg > max_reg)
                        max_reg <= sample_reg;
                end
                elh_pkg::ST_SUM_RD:
                begin
                end
                elh_pkg::ST_SUM_ACC:
                begin
                    total_reg <= total_reg + SUM_W'(cnt_val);
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_reg  <= '0;
                        run_reg  <= '0;
                        wsum_reg <= '0;
                        h95_reg  <= 1'b0;
                        h99_reg  <= 1'b0;
                        h999_reg <= 1'b0;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                elh_pkg::ST_DIV_LOAD:
                begin
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    num_reg  <= wsum_reg;
                    den_reg  <= ACC_W'(run_reg);
                end
                elh_pkg::ST_DIV_RUN:
                begin
                    // One restoring step; quotient bits shift into num_reg.
                    num_reg  <= {num_reg[ACC_W-2:0], div_bit};
                    rem_reg  <= div_bit ? ACC_W'(rem_shift - {1'b0, den_reg})
                                        : ACC_W'(rem_shift);
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                elh_pkg::ST_DIV_END:
                begin
                    // Ceiling of the mean, saturated to 32 bits.
                    if (num_reg[ACC_W-1:OW] != '0 || mean_inc[OW])
                        mean_reg <= '1;
                    else
                        mean_reg <= mean_inc[OW-1:0];
                end
                elh_pkg::ST_WALK_RD:
                begin
                    // Scaled totals; total_reg is fixed during the walk.
                    t95_reg  <= SC_W'(total_reg) * SC_W'(elh_pkg::P95_NUM);
                    t99_reg  <= SC_W'(total_reg) * SC_W'(elh_pkg::P99_NUM);
                    t999_reg <= SC_W'(total_reg) * SC_W'(elh_pkg::P999_NUM);
                end
                elh_pkg::ST_WALK_MUL:
                begin
                    bound_reg <= BOUNDS[idx_reg];
                    plo_reg   <= (CW+HALF)'(BOUNDS[idx_reg][HALF-1:0])
                                 * (CW+HALF)'(cnt_val);
                    phi_reg   <= (CW+HALF)'(BOUNDS[idx_reg][BW-1:HALF])
                                 * (CW+HALF)'(cnt_val);
                    run_reg   <= run_new;
                end
                elh_pkg::ST_WALK_PROD:
                begin
                    prod_reg <= (prod_full[BW+CW-1:ACC_W] != '0) ? '1
                                                                 : prod_full[ACC_W-1:0];
                    if (!h95_reg && hit95)
                    begin
                        v95_reg <= bound_reg;
                        h95_reg <= 1'b1;
                    end
                    if (!h99_reg && hit99)
                    begin
                        v99_reg <= bound_reg;
                        h99_reg <= 1'b1;
                    end
                    if (!h999_reg && hit999)
                    begin
                        v999_reg <= bound_reg;
                        h999_reg <= 1'b1;
                    end
                end
                elh_pkg::ST_WALK_SUM:
                begin
                    wsum_reg <= wsum_add[ACC_W] ? '1 : wsum_add[ACC_W-1:0];
                    if (idx_reg != LAST_IDX)
                        idx_reg <= idx_reg + 1'b1;
                end
                elh_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= {max_reg,
                                        (v999_reg[BW-1:OW] != '0) ? {OW{1'b1}}
                                                                  : v999_reg[OW-1:0],
                                        (v99_reg[BW-1:OW] != '0)  ? {OW{1'b1}}
                                                                  : v99_reg[OW-1:0],
                                        (v95_reg[BW-1:OW] != '0)  ? {OW{1'b1}}
                                                                  : v95_reg[OW-1:0],
                                        mean_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Chosen bucket never lies above the sample unless it is bucket zero.
    function automatic logic bound_ok(input logic [IDX_W-1:0] i);
        return (i == '0) || (BOUNDS[i] <= BW'(sample_reg));
    endfunction

    // Checks on the search, the update index and the result hand-off.
    `ASSERT_IMPLY(a_search_order, clk, rst_n,
        state_reg == elh_pkg::ST_SEARCH, lo_reg <= hi_reg)
    `ASSERT_IMPLY(a_update_index, clk, rst_n,
        state_reg == elh_pkg::ST_ADD_WR, idx_reg <= LAST_IDX && bound_ok(idx_reg))
    `ASSERT_NEXT(a_result_posted, clk, rst_n,
        state_reg == elh_pkg::ST_DONE && out_free, m_tvalid)

endmodule
